@@ sv/hfl_pkg.sv @@
// Package with the types and constants shared by the header field lookup modules.
`timescale 1ns / 1ps
package hfl_pkg;

	localparam int MAX_NAME_BYTES = 32;
	localparam int NAME_WORDS     = 4;
	localparam int NAME_BYTES     = NAME_WORDS * 8;
	localparam int CFG_INDEX_W    = 3;

	localparam logic [CFG_INDEX_W-1:0] CFG_NAME_LENGTH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NAME_WORD0  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_NAME_WORD1  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_NAME_WORD2  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_NAME_WORD3  = 3'd4;

	localparam logic [1:0] STATUS_NOT_FOUND = 2'd0;
	localparam logic [1:0] STATUS_FOUND     = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef enum logic [2:0] {
		PH_NAME  = 3'b001,
		PH_VALUE = 3'b010,
		PH_SKIP  = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_BYTE     = 2'd1,
		EV_LINE_END = 2'd2
	} ev_kind_t;

	// One classified input byte, as passed from the front end to the back end.
	typedef struct packed {
		logic        pre_cr;
		ev_kind_t    kind;
		logic [7:0]  ch;
		logic [15:0] pos;
		logic        last;
		logic        overflow;
	} token_t;

	typedef struct packed {
		logic [5:0]                len;
		logic                      usable;
		logic [NAME_BYTES-1:0][7:0] name;
	} target_t;

	typedef struct packed {
		phase_t      phase;
		logic [5:0]  name_index;
		logic        mismatch;
		logic [15:0] value_start;
		logic [15:0] value_end;
		logic        seen_text;
		logic        match_done;
		logic [15:0] match_offset;
		logic [15:0] match_length;
	} bstate_t;

	function automatic logic [7:0] fold_case(logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

endpackage

@@ sv/hfl_if.sv @@
// Channel interfaces of the header field lookup: input bytes, results and configuration.
`timescale 1ns / 1ps
interface hfl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_block;
	modport source (output valid, data_byte, end_of_block, input ready);
	modport sink (input valid, data_byte, end_of_block, output ready);
endinterface

interface hfl_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  lookup_status;
	logic [15:0] value_offset;
	logic [15:0] value_length;
	modport source (output valid, lookup_status, value_offset, value_length, input ready);
	modport sink (input valid, lookup_status, value_offset, value_length, output ready);
endinterface

interface hfl_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ sv/hfl_front.sv @@
// Front end: counts positions, resolves CR LF pairs and classifies each byte.
`timescale 1ns / 1ps
module hfl_front import hfl_pkg::*; #(
	parameter int MAX_BLOCK_BYTES = 65536
) (
	input  logic   clk,
	input  logic   arst_n,
	hfl_in_if.sink data,
	input  logic   queue_full,
	output logic   push,
	output token_t push_data
);

	localparam int PW = $clog2(MAX_BLOCK_BYTES + 2);
	localparam logic [PW-1:0] MAX_POS = PW'(MAX_BLOCK_BYTES);

	logic [PW-1:0] pos_q;
	logic          cr_pending_q;
	logic          is_lf;
	logic          is_cr;

	assign data.ready = !queue_full;
	assign push       = data.valid && data.ready;
	assign is_lf      = (data.data_byte == CH_LF);
	assign is_cr      = (data.data_byte == CH_CR);

	always_comb begin
		push_data.pre_cr   = cr_pending_q && !is_lf;
		push_data.ch       = data.data_byte;
		push_data.pos      = 16'(pos_q);
		push_data.last     = data.end_of_block;
		push_data.overflow = (pos_q >= MAX_POS);
		if (cr_pending_q && is_lf) begin
			push_data.kind = EV_LINE_END;
		end else if (is_cr && !data.end_of_block) begin
			push_data.kind = EV_NONE;
		end else begin
			// A CR that ends the block is an ordinary line byte.
			push_data.kind = EV_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			cr_pending_q <= 1'b0;
		end else if (push) begin
			if (data.end_of_block) begin
				pos_q        <= '0;
				cr_pending_q <= 1'b0;
			end else begin
				if (pos_q <= MAX_POS) begin
					pos_q <= pos_q + PW'(1);
				end
				cr_pending_q <= is_cr;
			end
		end
	end

endmodule

@@ sv/hfl_queue.sv @@
// Two-entry queue of classified bytes between the front end and the back end.
`timescale 1ns / 1ps
module hfl_queue import hfl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  token_t push_data,
	output logic   full,
	input  logic   pop,
	output token_t pop_data,
	output logic   empty
);

	token_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/hfl_back.sv @@
// Back end: matches line names, tracks the trimmed value and issues the status result.
`timescale 1ns / 1ps
module hfl_back import hfl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  target_t      target,
	input  logic         queue_empty,
	input  token_t       tok,
	output logic         pop,
	hfl_out_if.source    result
);

	localparam bstate_t ST_CLEAR = '{
		phase: PH_NAME, name_index: 6'd0, mismatch: 1'b0, value_start: 16'd0,
		value_end: 16'd0, seen_text: 1'b0, match_done: 1'b0, match_offset: 16'd0,
		match_length: 16'd0
	};

	bstate_t     st_q;
	bstate_t     st_next;
	bstate_t     st_done;
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [15:0] offset_q;
	logic [15:0] length_q;

	function automatic bstate_t line_byte(bstate_t s, logic [7:0] c, logic [15:0] pos,
		target_t t);
		bstate_t    r;
		logic [7:0] want;
		r    = s;
		want = s.name_index[5] ? 8'h00 : t.name[s.name_index[4:0]];
		unique case (s.phase)
			PH_NAME: begin
				if (c == CH_COLON) begin
					if (!s.match_done && t.usable && !s.mismatch &&
						s.name_index == t.len) begin
						r.phase     = PH_VALUE;
						r.seen_text = 1'b0;
					end else begin
						r.phase = PH_SKIP;
					end
				end else if (s.name_index >= t.len) begin
					r.mismatch = 1'b1;
				end else begin
					if (fold_case(c) != fold_case(want)) begin
						r.mismatch = 1'b1;
					end
					r.name_index = s.name_index + 6'd1;
				end
			end
			PH_VALUE: begin
				if (c != CH_SPACE && c != CH_TAB) begin
					if (!s.seen_text) begin
						r.value_start = pos;
						r.seen_text   = 1'b1;
					end
					r.value_end = pos + 16'd1;
				end
			end
			PH_SKIP: begin
				r = s;
			end
			default: begin
				r = s;
			end
		endcase
		return r;
	endfunction

	function automatic bstate_t line_end(bstate_t s, logic [15:0] pos);
		bstate_t r;
		r = s;
		if (s.phase == PH_VALUE && !s.match_done) begin
			r.match_done = 1'b1;
			if (s.seen_text) begin
				r.match_offset = s.value_start;
				r.match_length = s.value_end - s.value_start;
			end else begin
				r.match_offset = pos;
				r.match_length = 16'd0;
			end
		end
		r.phase      = PH_NAME;
		r.name_index = 6'd0;
		r.mismatch   = 1'b0;
		r.seen_text  = 1'b0;
		return r;
	endfunction

	// A token carries up to a pending CR, one byte or line end, and the block end.
	always_comb begin
		st_done = st_q;
		if (tok.pre_cr) begin
			st_done = line_byte(st_done, CH_CR, tok.pos - 16'd1, target);
		end
		unique case (tok.kind)
			EV_BYTE:     st_done = line_byte(st_done, tok.ch, tok.pos, target);
			EV_LINE_END: st_done = line_end(st_done, tok.pos - 16'd1);
			default:     st_done = st_done;
		endcase
		if (tok.last) begin
			st_done = line_end(st_done, tok.pos + 16'd1);
			st_next = ST_CLEAR;
		end else begin
			st_next = st_done;
		end
	end

	assign pop = !queue_empty && (!tok.last || !out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				st_q <= st_next;
			end
			if (pop && tok.last) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && tok.last) begin
			priority if (tok.overflow) begin
				status_q <= STATUS_OVERFLOW;
				offset_q <= 16'd0;
				length_q <= 16'd0;
			end else if (st_done.match_done) begin
				status_q <= STATUS_FOUND;
				offset_q <= st_done.match_offset;
				length_q <= st_done.match_length;
			end else begin
				status_q <= STATUS_NOT_FOUND;
				offset_q <= 16'd0;
				length_q <= 16'd0;
			end
		end
	end

	assign result.valid         = out_valid_q;
	assign result.lookup_status = status_q;
	assign result.value_offset  = offset_q;
	assign result.value_length  = length_q;

endmodule

@@ sv/header_field_lookup.sv @@
// Top level of the header field lookup: configuration registers and the front and back ends.
`timescale 1ns / 1ps
// The block takes one byte of a header block per clock cycle and keeps that rate with no
// gaps while the result side does not stall; every byte is classified by the front end
// and applied by the back end, and a two-entry queue between them absorbs a stall of the
// back end. The single status result of a block is held in an output register, so the
// first bytes of the next block are accepted while it waits. Configuration writes are
// taken in any cycle and should be made only while no block is in progress; writes to
// indexes beyond the name words are ignored.
module header_field_lookup import hfl_pkg::*; #(
	parameter int MAX_BLOCK_BYTES = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	hfl_in_if.sink     data,
	hfl_out_if.source  result,
	hfl_cfg_if.sink    cfg
);

	logic [5:0]                 name_len_q;
	logic [NAME_WORDS-1:0][63:0] name_word_q;
	target_t                    target;
	logic                       push;
	token_t                     push_data;
	logic                       queue_full;
	logic                       pop;
	token_t                     pop_data;
	logic                       queue_empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_len_q  <= 6'd1;
			name_word_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_NAME_LENGTH: name_len_q     <= cfg.data[5:0];
				CFG_NAME_WORD0:  name_word_q[0] <= cfg.data;
				CFG_NAME_WORD1:  name_word_q[1] <= cfg.data;
				CFG_NAME_WORD2:  name_word_q[2] <= cfg.data;
				CFG_NAME_WORD3:  name_word_q[3] <= cfg.data;
				default:         name_len_q     <= name_len_q;
			endcase
		end
	end

	always_comb begin
		target.len    = name_len_q;
		target.usable = (name_len_q != 6'd0) && (int'(name_len_q) <= MAX_NAME_BYTES);
		target.name   = name_word_q;
	end

	hfl_front #(
		.MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data       (data),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	hfl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (queue_empty)
	);

	hfl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.target      (target),
		.queue_empty (queue_empty),
		.tok         (pop_data),
		.pop         (pop),
		.result      (result)
	);

endmodule

@@ dv/tb_header_field_lookup.sv @@
// Self-checking testbench for header_field_lookup: directed and random header blocks against a predictor.
`timescale 1ns / 1ps
module tb_header_field_lookup;
	import hfl_pkg::*;

	localparam int BLOCK_LIMIT = 65536;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] offset;
		logic [15:0] len;
	} lookup_res_t;

	logic clk = 1'b0;
	logic arst_n;

	hfl_in_if  in_ch();
	hfl_out_if out_ch();
	hfl_cfg_if cfg_ch();

	header_field_lookup #(
		.MAX_BLOCK_BYTES(BLOCK_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.data(in_ch),
		.result(out_ch),
		.cfg(cfg_ch)
	);

	// Configuration as the block should hold it.
	logic [5:0]  tgt_len;
	logic [63:0] tgt_word [4];
	logic [7:0]  tgt_text [$];

	// Scan state of the block in progress.
	logic [16:0] blk_pos;
	phase_t      ln_phase;
	logic [5:0]  nm_idx;
	bit          nm_bad;
	bit          cr_held;
	bit          val_text;
	bit          hit_done;
	logic [15:0] val_start;
	logic [15:0] val_end;
	logic [15:0] hit_off;
	logic [15:0] hit_len;

	lookup_res_t expected_q [$];
	lookup_res_t res_want;
	int          err_count = 0;
	int          sent_bytes = 0;

	int tx_gap_max = 0;
	int tx_burst_left = 0;
	int rx_ready_pct = 100;
	int rx_hold_req = 0;
	int rx_hold_left = 0;
	int rx_run_left = 0;
	bit rx_run_level = 1'b1;

	string name_alphabet = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-";

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= 40) begin
			$display("MISMATCH at %0t ns: %s", $time, msg);
		end
	endtask

	// ---------------------------------------------------------------- predictor

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		if (c >= "A" && c <= "Z") begin
			return c + 8'd32;
		end
		return c;
	endfunction

	function automatic logic [7:0] target_char(input int i);
		if (i >= 32) begin
			return 8'h00;
		end
		return tgt_word[i / 8][(i % 8) * 8 +: 8];
	endfunction

	function automatic bit name_len_ok();
		return tgt_len >= 6'd1 && tgt_len <= MAX_NAME_BYTES;
	endfunction

	task automatic clear_scan();
		blk_pos = '0;
		ln_phase = PH_NAME;
		nm_idx = '0;
		nm_bad = 1'b0;
		cr_held = 1'b0;
		val_start = '0;
		val_end = '0;
		val_text = 1'b0;
		hit_done = 1'b0;
		hit_off = '0;
		hit_len = '0;
	endtask

	task automatic scan_char(input logic [7:0] c, input logic [16:0] pos);
		case (ln_phase)
			PH_NAME: begin
				if (c == CH_COLON) begin
					if (!hit_done && name_len_ok() && !nm_bad && nm_idx == tgt_len) begin
						ln_phase = PH_VALUE;
						val_text = 1'b0;
					end else begin
						ln_phase = PH_SKIP;
					end
				end else if (nm_idx >= tgt_len) begin
					nm_bad = 1'b1;
				end else begin
					if (to_lower(c) != to_lower(target_char(nm_idx))) begin
						nm_bad = 1'b1;
					end
					nm_idx++;
				end
			end
			PH_VALUE: begin
				if (c != CH_SPACE && c != CH_TAB) begin
					if (!val_text) begin
						val_start = pos[15:0];
						val_text = 1'b1;
					end
					val_end = pos[15:0] + 16'd1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic close_line(input logic [16:0] pos);
		if (ln_phase == PH_VALUE && !hit_done) begin
			hit_done = 1'b1;
			if (val_text) begin
				hit_off = val_start;
				hit_len = val_end - val_start;
			end else begin
				hit_off = pos[15:0];
				hit_len = '0;
			end
		end
		ln_phase = PH_NAME;
		nm_idx = '0;
		nm_bad = 1'b0;
		val_text = 1'b0;
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic last);
		logic [16:0] p;
		bit          took_lf;
		lookup_res_t r;
		p = blk_pos;
		took_lf = 1'b0;
		// A held CR becomes a line end only when LF follows it.
		if (cr_held) begin
			cr_held = 1'b0;
			if (b == CH_LF) begin
				close_line(p - 17'd1);
				took_lf = 1'b1;
			end else begin
				scan_char(CH_CR, p - 17'd1);
			end
		end
		if (!took_lf) begin
			if (b == CH_CR) begin
				cr_held = 1'b1;
			end else begin
				scan_char(b, p);
			end
		end
		if (blk_pos <= BLOCK_LIMIT) begin
			blk_pos++;
		end
		if (last) begin
			if (cr_held) begin
				cr_held = 1'b0;
				scan_char(CH_CR, p);
			end
			close_line(blk_pos);
			if (blk_pos > BLOCK_LIMIT) begin
				r = '{STATUS_OVERFLOW, 16'd0, 16'd0};
			end else if (hit_done) begin
				r = '{STATUS_FOUND, hit_off, hit_len};
			end else begin
				r = '{STATUS_NOT_FOUND, 16'd0, 16'd0};
			end
			expected_q.push_back(r);
			clear_scan();
		end
	endtask

	// ---------------------------------------------------------------- result check

	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result with none expected (status %0d)",
					out_ch.lookup_status));
			end else begin
				res_want = expected_q.pop_front();
				if (out_ch.lookup_status !== res_want.status) begin
					report_mismatch($sformatf("lookup_status %0d, expected %0d",
						out_ch.lookup_status, res_want.status));
				end
				if (out_ch.value_offset !== res_want.offset) begin
					report_mismatch($sformatf("value_offset %0d, expected %0d",
						out_ch.value_offset, res_want.offset));
				end
				if (out_ch.value_length !== res_want.len) begin
					report_mismatch($sformatf("value_length %0d, expected %0d",
						out_ch.value_length, res_want.len));
				end
			end
		end
	end

	// Receiver: runs of random length at one ready level, or a long hold-off on request.
	always @(posedge clk) begin
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req <= 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			if (rx_run_left == 0) begin
				rx_run_left = $urandom_range(1, 12);
				rx_run_level = ($urandom_range(0, 99) < rx_ready_pct);
			end
			rx_run_left--;
			out_ch.ready <= rx_run_level;
		end
	end

	// ---------------------------------------------------------------- drivers

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			CFG_NAME_LENGTH: tgt_len = val[5:0];
			CFG_NAME_WORD0: tgt_word[0] = val;
			CFG_NAME_WORD1: tgt_word[1] = val;
			CFG_NAME_WORD2: tgt_word[2] = val;
			CFG_NAME_WORD3: tgt_word[3] = val;
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (tx_burst_left == 0) begin
			tx_burst_left = $urandom_range(1, 24);
			gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		tx_burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.end_of_block <= last;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sent_bytes++;
		predict_byte(b, last);
	endtask

	task automatic send_block(input logic [7:0] blk [$]);
		for (int i = 0; i < blk.size(); i++) begin
			send_byte(blk[i], i == blk.size() - 1);
		end
	endtask

	task automatic add_text(ref logic [7:0] blk [$], input string s);
		for (int i = 0; i < s.len(); i++) begin
			blk.push_back(s[i]);
		end
	endtask

	task automatic send_text(input string s);
		logic [7:0] blk [$];
		add_text(blk, s);
		send_block(blk);
	endtask

	// Stops offering input and waits for every outstanding transaction to come back.
	task automatic wait_idle();
		int waited;
		waited = 0;
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_q.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
			expected_q.delete();
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic set_pace(input int gap_max, input int ready_pct);
		tx_gap_max = gap_max;
		rx_ready_pct <= ready_pct;
	endtask

	task automatic program_bytes(input logic [7:0] nm [$], input logic [5:0] len);
		logic [63:0] w;
		tgt_text = nm;
		for (int k = 0; k < 4; k++) begin
			w = {$urandom, $urandom};
			for (int j = 0; j < 8; j++) begin
				if (k * 8 + j < nm.size()) begin
					w[j * 8 +: 8] = nm[k * 8 + j];
				end
			end
			write_reg(CFG_NAME_WORD0 + 3'(k), w);
		end
		// Bits above the length field carry junk that must be dropped.
		write_reg(CFG_NAME_LENGTH, ({$urandom, $urandom} & ~64'h3F) | 64'(len));
	endtask

	task automatic program_name(input string s);
		logic [7:0] nm [$];
		add_text(nm, s);
		program_bytes(nm, 6'(nm.size()));
	endtask

	// ---------------------------------------------------------------- stimulus content

	function automatic logic [7:0] rand_blank();
		return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB;
	endfunction

	function automatic logic [7:0] rand_name_char();
		logic [7:0] c;
		if ($urandom_range(0, 6) != 0) begin
			return name_alphabet[$urandom_range(0, name_alphabet.len() - 1)];
		end
		do c = 8'($urandom); while (c == CH_CR || c == CH_LF || c == CH_COLON);
		return c;
	endfunction

	function automatic logic [7:0] rand_value_char();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			return 8'($urandom_range(8'h21, 8'h7E));
		end
		if (pick < 88) begin
			return rand_blank();
		end
		if (pick < 94) begin
			return CH_CR;
		end
		return 8'($urandom_range(8'h80, 8'hFF));
	endfunction

	function automatic logic [7:0] flip_case(input logic [7:0] c);
		if ($urandom_range(0, 1) == 0) begin
			return c;
		end
		if (c >= "a" && c <= "z") begin
			return c - 8'd32;
		end
		if (c >= "A" && c <= "Z") begin
			return c + 8'd32;
		end
		return c;
	endfunction

	task automatic add_target_name(ref logic [7:0] blk [$], input bit mutate);
		logic [7:0] nm [$];
		int         k;
		nm = tgt_text;
		if (mutate && nm.size() > 0) begin
			k = $urandom_range(0, nm.size() - 1);
			case ($urandom_range(0, 2))
				0: nm.delete(k);
				1: nm.insert(k, rand_name_char());
				default: nm[k] = rand_name_char();
			endcase
		end
		foreach (nm[i]) begin
			blk.push_back(flip_case(nm[i]));
		end
	endtask

	task automatic add_value(ref logic [7:0] blk [$]);
		blk.push_back(CH_COLON);
		repeat ($urandom_range(0, 3)) blk.push_back(rand_blank());
		repeat ($urandom_range(0, 8)) blk.push_back(rand_value_char());
		repeat ($urandom_range(0, 3)) blk.push_back(rand_blank());
	endtask

	task automatic add_line(ref logic [7:0] blk [$], input bit crlf);
		int         kind;
		logic [7:0] c;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			add_target_name(blk, $urandom_range(0, 4) == 0);
			add_value(blk);
		end else if (kind < 65) begin
			repeat ($urandom_range(0, 6)) blk.push_back(rand_name_char());
			add_value(blk);
		end else if (kind < 78) begin
			repeat ($urandom_range(1, 10)) begin
				c = rand_value_char();
				blk.push_back((c == CH_COLON) ? 8'h5F : c);
			end
		end else if (kind < 90) begin
			repeat ($urandom_range(1, 6)) blk.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(0, 3)) blk.push_back(rand_blank());
		end
		if (crlf) begin
			blk.push_back(CH_CR);
			blk.push_back(CH_LF);
		end
	endtask

	task automatic build_block(ref logic [7:0] blk [$]);
		int lines;
		blk = {};
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 4)) blk.push_back(8'($urandom));
		end else begin
			lines = $urandom_range(1, 4);
			for (int i = 0; i < lines; i++) begin
				add_line(blk, (i < lines - 1) || ($urandom_range(0, 1) == 1));
			end
		end
		if (blk.size() == 0) begin
			blk.push_back(8'($urandom));
		end
	endtask

	task automatic random_target();
		logic [7:0] nm [$];
		int         n;
		int         pick;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			n = $urandom_range(1, 8);
		end else if (pick < 9) begin
			n = $urandom_range(9, 31);
		end else begin
			n = MAX_NAME_BYTES;
		end
		repeat (n) nm.push_back(rand_name_char());
		program_bytes(nm, 6'(n));
	endtask

	// ---------------------------------------------------------------- tests

	// The reset name is one NUL byte, so a NUL before the colon matches.
	task automatic test_reset_name();
		logic [7:0] blk [$];
		set_pace(0, 100);
		blk.push_back(8'h00);
		blk.push_back(CH_COLON);
		blk.push_back(CH_SPACE);
		blk.push_back(8'hFF);
		send_block(blk);
		wait_idle();
	endtask

	task automatic test_line_rules();
		set_pace(2, 70);
		program_name("Host");
		send_text("hOsT:  a b \t\015\012");
		send_text("X: y\015\012host:z");
		send_text("Host\015\012HOST: b\015\012");
		send_text("Host: \t \015\012q");
		send_text("Host: \t");
		send_text("Host: a\015b \015\012");
		send_text("Host: a\015");
		send_text("Host: 1\015\012Host: 2");
		send_text("Hosts: x\015\012Hos: y\015\012");
		send_text(":");
		send_text("\015\015\012Host:x:y\015\012");
		wait_idle();
	endtask

	task automatic test_name_lengths();
		logic [7:0] nm [$];
		logic [7:0] blk [$];
		set_pace(1, 90);
		// Longest usable name, with every byte compared.
		repeat (MAX_NAME_BYTES) nm.push_back(name_alphabet[$urandom_range(0, 25)]);
		program_bytes(nm, 6'(MAX_NAME_BYTES));
		add_target_name(blk, 1'b0);
		add_text(blk, ": long");
		send_block(blk);
		wait_idle();

		// All-ones name words.
		write_reg(CFG_NAME_WORD0, '1);
		write_reg(CFG_NAME_WORD1, '1);
		write_reg(CFG_NAME_WORD2, '1);
		write_reg(CFG_NAME_WORD3, '1);
		write_reg(CFG_NAME_LENGTH, 64'd8);
		blk = {};
		repeat (8) blk.push_back(8'hFF);
		add_text(blk, ":v\015\012");
		send_block(blk);
		blk.push_front(8'hFF);
		send_block(blk);
		wait_idle();

		// Zero length matches nothing, not even an empty name.
		write_reg(CFG_NAME_LENGTH, 64'd0);
		send_text(":x\015\012a:x");
		wait_idle();

		// Lengths beyond the name store match nothing.
		nm.push_back("z");
		program_bytes(nm, 6'(MAX_NAME_BYTES + 1));
		blk = {};
		add_target_name(blk, 1'b0);
		add_text(blk, ":w");
		send_block(blk);
		wait_idle();
		write_reg(CFG_NAME_LENGTH, 64'd63);
		send_block(blk);
		wait_idle();

		// Writes past the last name word must leave the name alone.
		program_name("Host");
		write_reg(CFG_NAME_WORD3 + 3'd1, {$urandom, $urandom});
		write_reg(CFG_NAME_WORD3 + 3'd2, {$urandom, $urandom});
		write_reg(CFG_NAME_WORD3 + 3'd3, {$urandom, $urandom});
		send_text("host: ok");
		wait_idle();
	endtask

	// The receiver stops for a long stretch while short blocks keep coming,
	// so the output register and the internal queue fill and input stalls.
	task automatic test_backpressure();
		set_pace(0, 100);
		program_name("Host");
		rx_hold_req <= 300;
		repeat (20) begin
			send_text(":");
			send_text("host: v");
		end
		wait_idle();
	endtask

	task automatic test_random_traffic();
		logic [7:0] blk [$];
		int         bytes_start;
		int         blocks;
		bytes_start = sent_bytes;
		blocks = 0;
		while (sent_bytes - bytes_start < 1600 || blocks < 60) begin
			case ($urandom_range(0, 3))
				0: set_pace(0, 100);
				1: set_pace(3, 80);
				2: set_pace(12, 50);
				default: set_pace(1, 25);
			endcase
			if ($urandom_range(0, 3) != 0) begin
				random_target();
			end
			repeat ($urandom_range(4, 10)) begin
				build_block(blk);
				send_block(blk);
				blocks++;
			end
			wait_idle();
		end
	endtask

	// Blocks at the edge of the position range: offsets wrap to 16 bits and
	// one byte more than the range gives overflow even with a match inside.
	task automatic test_long_blocks();
		logic [7:0] blk [$];
		set_pace(0, 100);
		program_name("Host");
		while (blk.size() < BLOCK_LIMIT - 9) blk.push_back("x");
		add_text(blk, "\015\012Host:zz");
		send_block(blk);

		blk = {};
		while (blk.size() < BLOCK_LIMIT - 9) blk.push_back("x");
		add_text(blk, "\015\012host: \t");
		send_block(blk);

		blk = {};
		add_text(blk, "Host: v\015\012");
		while (blk.size() < BLOCK_LIMIT + 1) blk.push_back("y");
		send_block(blk);
		wait_idle();
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.end_of_block = 1'b0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		tgt_len = 6'd1;
		for (int k = 0; k < 4; k++) begin
			tgt_word[k] = '0;
		end
		tgt_text = {8'h00};
		clear_scan();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_name();
		test_line_rules();
		test_name_lengths();
		test_backpressure();
		test_random_traffic();
		test_long_blocks();

		wait_idle();
		if (err_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

endmodule
